[rtl/core/ptlm_pkg.sv]
// Shared types for the per-tag latest-max tracker.
package ptlm_pkg;

    // One incoming signal report.
    typedef struct packed {
        logic [31:0]        tag_id;
        logic signed [15:0] snr;
        logic               confirmed;
        logic [3:0]         source_label;
    } req_t;

    // One result with the current view and change flags.
    typedef struct packed {
        logic signed [15:0] display_snr;
        logic               display_valid;
        logic [3:0]         display_label;
        logic               low_confidence_only;
        logic signed [15:0] confirmed_max_snr;
        logic               confirmed_max_valid;
        logic               display_snr_changed;
        logic               display_label_changed;
        logic               low_only_changed;
        logic               confirmed_max_changed;
        logic               table_full_drop;
    } rsp_t;

    // Confirmed and low-confidence maxima kept between reports.
    typedef struct packed {
        logic signed [15:0] conf_max;
        logic [3:0]         conf_label;
        logic               conf_ok;
        logic signed [15:0] low_max;
        logic [3:0]         low_label;
        logic               low_ok;
    } track_state_t;

    // One slot of the tag table.
    typedef struct packed {
        logic [31:0]        tag;
        logic signed [15:0] snr;
        logic [3:0]         label;
    } slot_entry_t;

endpackage

[rtl/core/ptlm_view.sv]
// Display selection and change flags from the maxima before and after a request.
module ptlm_view
    import ptlm_pkg::*;
(
    input  track_state_t old_st,
    input  track_state_t new_st,
    input  logic         applied,
    input  logic         drop,
    output rsp_t         rsp
);

    logic signed [15:0] od_snr, nd_snr;
    logic               od_valid, nd_valid;
    logic [3:0]         od_label, nd_label;
    logic               old_low_only, new_low_only;
    logic               snr_ch, lab_ch, cm_ch;

    // Displayed value: confirmed max first, then low-confidence max
    always_comb begin
        if (old_st.conf_ok) begin
            od_snr = old_st.conf_max; od_valid = 1'b1; od_label = old_st.conf_label;
        end else if (old_st.low_ok) begin
            od_snr = old_st.low_max;  od_valid = 1'b1; od_label = old_st.low_label;
        end else begin
            od_snr = '0;              od_valid = 1'b0; od_label = '0;
        end
        if (new_st.conf_ok) begin
            nd_snr = new_st.conf_max; nd_valid = 1'b1; nd_label = new_st.conf_label;
        end else if (new_st.low_ok) begin
            nd_snr = new_st.low_max;  nd_valid = 1'b1; nd_label = new_st.low_label;
        end else begin
            nd_snr = '0;              nd_valid = 1'b0; nd_label = '0;
        end
    end

    // Change detection
    assign old_low_only = !old_st.conf_ok && old_st.low_ok;
    assign new_low_only = !new_st.conf_ok && new_st.low_ok;
    assign snr_ch = (od_valid != nd_valid) || (nd_valid && (od_snr != nd_snr));
    assign lab_ch = (od_label != nd_label);
    assign cm_ch  = (old_st.conf_ok != new_st.conf_ok) ||
                    (new_st.conf_ok && ((old_st.conf_max != new_st.conf_max) ||
                                        (old_st.conf_label != new_st.conf_label)));

    // Result assembly
    always_comb begin
        rsp.display_snr           = nd_snr;
        rsp.display_valid         = nd_valid;
        rsp.display_label         = nd_label;
        rsp.low_confidence_only   = new_low_only;
        rsp.confirmed_max_snr     = new_st.conf_ok ? new_st.conf_max : 16'sd0;
        rsp.confirmed_max_valid   = new_st.conf_ok;
        rsp.display_snr_changed   = applied && snr_ch;
        rsp.display_label_changed = applied && lab_ch;
        rsp.low_only_changed      = applied && (old_low_only != new_low_only);
        rsp.confirmed_max_changed = applied && cm_ch;
        rsp.table_full_drop       = drop;
    end

endmodule

[rtl/core/per_tag_latest_max_tracker_top.sv]
// Top level of the per-tag latest-max tracker: slot memory, scan sequencer, result register.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_data (req_t)
//  m_      | out       | m_valid / m_ready  | m_data (rsp_t)
//
// A confirmed request passes from acceptance through a scan that reads one slot
// memory entry per cycle over the whole table, a resolve state for the last read to
// land, and a write-back state that loads the result, then returns to idle for the next.
// A low-confidence request goes from idle straight to write-back and does not touch the memory.
// Reset clears the slot valid bits and the maxima; slot contents need no clearing.
// A result waits in the output register; the write-back cycle stalls while it is held.
module per_tag_latest_max_tracker_top
    import ptlm_pkg::*;
#(
    parameter int TAG_SLOTS = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    localparam int AW = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_FIN
    } state_t;

    state_t             state_reg;
    req_t               req_reg;
    logic [AW-1:0]      scan_cnt_reg;
    logic [TAG_SLOTS-1:0] valid_reg;
    track_state_t       st_reg, st_next;
    logic               m_valid_reg;
    rsp_t               m_data_reg;

    // slot memory and its read port
    slot_entry_t        mem [TAG_SLOTS];
    slot_entry_t        rd_entry_reg;
    logic [AW-1:0]      rd_idx_reg;
    logic               rd_vld_reg;

    // scan accumulators
    logic               hit_found_reg, free_found_reg, best_ok_reg;
    logic [AW-1:0]      hit_idx_reg, free_idx_reg;
    logic signed [15:0] hit_snr_reg, best_snr_reg;
    logic [3:0]         hit_label_reg, best_label_reg;
    logic [31:0]        best_tag_reg;

    logic               cur_valid, tag_eq, take_hit, take_free, take_best;
    logic               fin_go, hit_same, conf_applied, low_applied, applied, drop;
    logic               new_wins, mem_we;
    logic [AW-1:0]      wr_addr;
    slot_entry_t        wr_entry;
    rsp_t               rsp;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Per-slot decisions on the entry just read
    assign cur_valid = valid_reg[rd_idx_reg];
    assign tag_eq    = (rd_entry_reg.tag == req_reg.tag_id);
    assign take_hit  = cur_valid && tag_eq && !hit_found_reg;
    assign take_free = !cur_valid && !free_found_reg;
    assign take_best = cur_valid && !tag_eq &&
                       (!best_ok_reg || (rd_entry_reg.snr > best_snr_reg) ||
                        ((rd_entry_reg.snr == best_snr_reg) &&
                         (rd_entry_reg.tag < best_tag_reg)));

    // Write-back decisions
    assign fin_go       = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);
    assign hit_same     = (hit_snr_reg == req_reg.snr) &&
                          (hit_label_reg == req_reg.source_label);
    assign conf_applied = hit_found_reg ? !hit_same : free_found_reg;
    assign low_applied  = !st_reg.low_ok || (req_reg.snr > st_reg.low_max);
    assign applied      = req_reg.confirmed ? conf_applied : low_applied;
    assign drop         = req_reg.confirmed && !hit_found_reg && !free_found_reg;
    // the updated entry competes with every other slot's best
    assign new_wins     = !best_ok_reg || (req_reg.snr > best_snr_reg) ||
                          ((req_reg.snr == best_snr_reg) && (req_reg.tag_id < best_tag_reg));
    assign mem_we       = fin_go && req_reg.confirmed && conf_applied;
    assign wr_addr      = hit_found_reg ? hit_idx_reg : free_idx_reg;
    assign wr_entry     = '{tag: req_reg.tag_id, snr: req_reg.snr,
                            label: req_reg.source_label};

    // Next maxima
    always_comb begin
        st_next = st_reg;
        if (req_reg.confirmed && conf_applied) begin
            st_next.conf_ok    = 1'b1;
            st_next.conf_max   = new_wins ? req_reg.snr : best_snr_reg;
            st_next.conf_label = new_wins ? req_reg.source_label : best_label_reg;
        end
        if (!req_reg.confirmed && low_applied) begin
            st_next.low_ok    = 1'b1;
            st_next.low_max   = req_reg.snr;
            st_next.low_label = req_reg.source_label;
        end
    end

    ptlm_view u_view (
        .old_st  (st_reg),
        .new_st  (st_next),
        .applied (applied),
        .drop    (drop),
        .rsp     (rsp)
    );

    // Slot memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_entry;
        end
        rd_entry_reg <= mem[scan_cnt_reg];
        rd_idx_reg   <= scan_cnt_reg;
    end

    // Sequencer, accumulators and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
            st_reg      <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            rd_vld_reg <= (state_reg == ST_SCAN);
            if (fin_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg        <= s_data;
                        scan_cnt_reg   <= '0;
                        hit_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        best_ok_reg    <= 1'b0;
                        state_reg      <= s_data.confirmed ? ST_SCAN : ST_FIN;
                    end
                end
                ST_SCAN: begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (scan_cnt_reg == AW'(TAG_SLOTS - 1)) begin
                        state_reg <= ST_RESOLVE;
                    end
                end
                ST_RESOLVE: begin
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (fin_go) begin
                        m_data_reg  <= rsp;
                        st_reg      <= st_next;
                        if (mem_we && !hit_found_reg) begin
                            valid_reg[free_idx_reg] <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            // fold the slot that came out of memory into the scan results
            if (rd_vld_reg) begin
                if (take_hit) begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= rd_idx_reg;
                    hit_snr_reg   <= rd_entry_reg.snr;
                    hit_label_reg <= rd_entry_reg.label;
                end
                if (take_free) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= rd_idx_reg;
                end
                if (take_best) begin
                    best_ok_reg    <= 1'b1;
                    best_snr_reg   <= rd_entry_reg.snr;
                    best_tag_reg   <= rd_entry_reg.tag;
                    best_label_reg <= rd_entry_reg.label;
                end
            end
        end
    end

`ifndef SYNTHESIS
    // a confirmed maximum exists exactly when the table holds an entry
    a_conf_ok_matches_table: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.conf_ok == (|valid_reg))
        else $error("confirmed max validity disagrees with slot valid bits");

    // a drop is only reported while every slot is used
    a_drop_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.table_full_drop) |-> (&valid_reg))
        else $error("table full drop with a free slot");

    // a dropped request changes nothing in the view
    a_drop_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.table_full_drop) |->
        !(m_data_reg.display_snr_changed || m_data_reg.display_label_changed ||
          m_data_reg.low_only_changed || m_data_reg.confirmed_max_changed))
        else $error("change flag set on a dropped request");

    // the confirmed maximum never goes away once found
    a_conf_ok_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.conf_ok |=> st_reg.conf_ok)
        else $error("confirmed max validity dropped");
`endif

endmodule
